FILE: src/lsss_pkg.sv
// Shared types and constants for the light-seeking servo scanner.
// No dependencies; imported by lsss_step and light_seek_servo_scan.
`default_nettype none

package lsss_pkg;

	// Field widths
	localparam int SAMPLE_BITS = 10;
	localparam int ANGLE_W     = 8;
	localparam int TIMEOUT_W   = 24;
	localparam int WINDOW_W    = 10;
	localparam int CAUSE_W     = 2;

	// Sweep end angle in degrees
	localparam int SWEEP_END_DEG = 180;

	// Register reset values
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = '0;
	localparam logic [WINDOW_W-1:0]  WINDOW_RST  = WINDOW_W'(100);

	// Register map, selected by paddr[2]
	localparam int  PADDR_W  = 3;
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_WINDOW  = 1'b1;

	// Scan start causes
	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_LIGHT   = 2'd1,
		CAUSE_TIMEOUT = 2'd2,
		CAUSE_BUTTON  = 2'd3
	} lsss_cause_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [WINDOW_W-1:0]  window_half_width;
	} lsss_cfg_t;

	typedef struct packed {
		logic                   scanning;
		logic [ANGLE_W-1:0]     sweep_angle;
		logic [SAMPLE_BITS-1:0] best_level;
		logic [ANGLE_W-1:0]     best_heading;
		logic [TIMEOUT_W-1:0]   idle_ticks;
		logic [ANGLE_W-1:0]     servo_position;
	} lsss_state_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]     servo_target;
		logic                   lamp_on;
		logic                   sweep_done;
		lsss_cause_t            start_cause;
		logic [SAMPLE_BITS-1:0] peak_light;
	} lsss_result_t;

endpackage

`default_nettype wire

FILE: src/lsss_step.sv
// Next-state and result logic for one tick of the scanner.
// Depends on lsss_pkg; purely combinational, used by light_seek_servo_scan.
`default_nettype none

module lsss_step
	import lsss_pkg::*;
(
	input  lsss_cfg_t              cfg,
	input  lsss_state_t            state_q,
	input  logic [SAMPLE_BITS-1:0] raw_light,
	input  logic                   button_held,
	output lsss_state_t            state_d,
	output lsss_result_t           result
);

	logic [SAMPLE_BITS-1:0] level;
	logic [SAMPLE_BITS:0]   lo_sum;
	logic [SAMPLE_BITS:0]   hi_sum;
	logic                   out_of_window;
	logic [TIMEOUT_W-1:0]   idle_inc;
	logic                   timed_out;
	lsss_cause_t            cause;
	logic                   done;
	logic                   brighter;
	logic [ANGLE_W-1:0]     heading_new;

	// Invert sample so that brighter reads higher
	assign level = ~raw_light;

	// Window test: level < best - w  <=>  level + w < best
	assign lo_sum = {1'b0, level} + (SAMPLE_BITS+1)'(cfg.window_half_width);
	assign hi_sum = {1'b0, state_q.best_level} + (SAMPLE_BITS+1)'(cfg.window_half_width);
	assign out_of_window = (lo_sum < {1'b0, state_q.best_level}) ||
		({1'b0, level} > hi_sum);

	// Idle count, wraps at its width
	assign idle_inc  = state_q.idle_ticks + TIMEOUT_W'(1);
	assign timed_out = (cfg.timeout_ticks != '0) && (idle_inc == cfg.timeout_ticks);

	// Sweep tracking; ties keep the first angle
	assign brighter    = level > state_q.best_level;
	assign heading_new = brighter ? state_q.sweep_angle : state_q.best_heading;

	always_comb begin
		state_d = state_q;
		cause   = CAUSE_NONE;
		done    = 1'b0;
		if (!state_q.scanning) begin
			// Monitor mode: priority button, light moved, timeout
			if (button_held) begin
				cause = CAUSE_BUTTON;
			end else begin
				state_d.idle_ticks = idle_inc;
				if (out_of_window)
					cause = CAUSE_LIGHT;
				else if (timed_out)
					cause = CAUSE_TIMEOUT;
			end
			if (cause != CAUSE_NONE) begin
				state_d.scanning       = 1'b1;
				state_d.sweep_angle    = '0;
				state_d.best_level     = '0;
				state_d.idle_ticks     = '0;
				state_d.servo_position = '0;
			end
		end else begin
			// Scan mode: one sample per angle
			if (brighter)
				state_d.best_level = level;
			state_d.best_heading = heading_new;
			if (state_q.sweep_angle >= ANGLE_W'(SWEEP_END_DEG)) begin
				state_d.scanning       = 1'b0;
				state_d.servo_position = heading_new;
				done                   = 1'b1;
			end else begin
				state_d.sweep_angle    = state_q.sweep_angle + ANGLE_W'(1);
				state_d.servo_position = state_q.sweep_angle + ANGLE_W'(1);
			end
		end
	end

	// Result reflects the state after this tick
	always_comb begin
		result.servo_target = state_d.servo_position;
		result.lamp_on      = state_d.scanning;
		result.sweep_done   = done;
		result.start_cause  = cause;
		result.peak_light   = state_d.best_level;
	end

endmodule

`default_nettype wire

FILE: src/light_seek_servo_scan.sv
// Top level of the light-seeking servo scanner: stream ports, APB registers,
// input and result registers. Depends on lsss_pkg and lsss_step.
`default_nettype none

// One light sample per transfer in, one result per transfer out. A sample
// enters an input register, the scan state and the result are updated from
// it as it leaves that register, and the result sits in an output register.
// A new sample is taken every cycle while the output is drained, the rate
// being set by the state update loop. In monitor mode the block starts a
// sweep when the button is held, when the inverted light level leaves
// best_level +/- window_half_width, or when the idle count hits timeout_ticks
// (zero disables). A sweep takes SWEEP_END_DEG+1 samples, one per degree
// from 0, then parks the servo at the brightest angle and raises tlast.
// Registers: 0x0 timeout_ticks[23:0], 0x4 window_half_width[9:0] (reset 100);
// write them only while no sample is in flight.
module light_seek_servo_scan
	import lsss_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// Sample stream in
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [15:0]        s_tdata,   // [9:0] raw_light, [15:10] zero
	input  wire logic               s_tuser,   // [0] button_held
	// Result stream out
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [23:0]             m_tdata,   // [7:0] servo_target, [17:8] peak_light
	output logic                    m_tlast,   // sweep_done
	output logic [2:0]              m_tuser    // [0] lamp_on, [2:1] start_cause
);

	lsss_cfg_t              cfg_q;
	lsss_state_t            state_q;
	lsss_state_t            state_d;
	lsss_result_t           result;
	lsss_result_t           result_s2;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] raw_s1;
	logic                   button_s1;
	logic                   valid_s2;
	logic                   advance;
	logic                   cfg_wr;

	// APB: always ready, register picked by paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks     <= TIMEOUT_RST;
			cfg_q.window_half_width <= WINDOW_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_TIMEOUT)
				cfg_q.timeout_ticks <= pwdata[TIMEOUT_W-1:0];
			else
				cfg_q.window_half_width <= pwdata[WINDOW_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_TIMEOUT)
			prdata = 32'(cfg_q.timeout_ticks);
		else
			prdata = 32'(cfg_q.window_half_width);
	end

	// Pipeline moves when the result register is free or being drained
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1    <= s_tdata[SAMPLE_BITS-1:0];
			button_s1 <= s_tuser;
		end
	end

	lsss_step u_step (
		.cfg         (cfg_q),
		.state_q     (state_q),
		.raw_light   (raw_s1),
		.button_held (button_s1),
		.state_d     (state_d),
		.result      (result)
	);

	// Scan state, updated as each sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, result_s2.peak_light, result_s2.servo_target};
	assign m_tlast  = result_s2.sweep_done;
	assign m_tuser  = {result_s2.start_cause, result_s2.lamp_on};

	// A finished sweep turns the lamp off
	a_done_lamp_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser[0])
		else $error("sweep_done with lamp still on");

	// A started scan points the servo at angle zero with the lamp on
	a_start_home: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:1] != CAUSE_NONE) |-> m_tuser[0] && (m_tdata[7:0] == '0))
		else $error("scan start without lamp or home position");

	// The sweep never passes the end angle
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.scanning |-> (state_q.sweep_angle <= ANGLE_W'(SWEEP_END_DEG)))
		else $error("sweep angle beyond end");

	// Scan state moves only when a sample is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(state_q))
		else $error("scan state changed without a sample");

endmodule

`default_nettype wire
